>>> rtl/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared types, constants and symbol tables for the Moore curve generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int DEG_W              = 4;
  localparam int COORD_W            = 15;
  localparam int LEFT_W             = 30;
  localparam int FRAME_W            = 5;
  localparam int POS_W              = 4;
  localparam int DEFAULT_MAX_DEGREE = 15;
  localparam int AXIOM_LEN          = 9;
  localparam int RULE_LEN           = 11;

  typedef enum logic [2:0] {
    SYM_F,
    SYM_PLUS,
    SYM_MINUS,
    SYM_L,
    SYM_R
  } sym_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP,
    ST_EMIT
  } state_e;

  // Axiom LFL+F+LFL
  function automatic sym_e axiom_sym(input logic [POS_W-1:0] pos);
    sym_e s;
    case (pos)
      4'd0:    s = SYM_L;
      4'd1:    s = SYM_F;
      4'd2:    s = SYM_L;
      4'd3:    s = SYM_PLUS;
      4'd4:    s = SYM_F;
      4'd5:    s = SYM_PLUS;
      4'd6:    s = SYM_L;
      4'd7:    s = SYM_F;
      4'd8:    s = SYM_L;
      default: s = SYM_F;
    endcase
    return s;
  endfunction

  // L = -RF+LFL+FR-   R = +LF-RFR-FL+
  function automatic sym_e rule_sym(input logic is_r, input logic [POS_W-1:0] pos);
    sym_e s;
    sym_e turn_a;
    sym_e turn_b;
    sym_e var_a;
    sym_e var_b;
    turn_a = is_r ? SYM_PLUS : SYM_MINUS;
    turn_b = is_r ? SYM_MINUS : SYM_PLUS;
    var_a  = is_r ? SYM_L : SYM_R;
    var_b  = is_r ? SYM_R : SYM_L;
    case (pos)
      4'd0:    s = turn_a;
      4'd1:    s = var_a;
      4'd2:    s = SYM_F;
      4'd3:    s = turn_b;
      4'd4:    s = var_b;
      4'd5:    s = SYM_F;
      4'd6:    s = var_b;
      4'd7:    s = turn_b;
      4'd8:    s = SYM_F;
      4'd9:    s = var_a;
      4'd10:   s = turn_a;
      default: s = SYM_F;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/moore_curve_point_generator.sv
// ----------------------------------------------------------------------------
// moore_curve_point_generator
// Walks the Moore curve L-system as a turtle and returns one point per beat.
// ----------------------------------------------------------------------------
// Each input beat returns one output beat holding the next curve point; the
// first beat after reset, after the last point, after a degree write, or
// with restart set returns the start point (2^(degree-1)-1, 0). A walk step
// handles symbols one at a time (turns, expansions, the F itself); closing
// an expansion level first drops the level, then reads the frame below from
// the expansion stack memory (the outermost level needs only the drop). The
// stack memory, with one write port and one registered read port, is touched
// at most once per cycle. The result sits in an output register, so the next
// beat is taken while a finished point still waits downstream. No clearing
// pass is needed after reset: every stack entry is written before it is read.
// ----------------------------------------------------------------------------
module moore_curve_point_generator #(
  parameter int MAX_DEGREE = mcpg_pkg::DEFAULT_MAX_DEGREE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [mcpg_pkg::DEG_W-1:0]   cfg_wdata_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         in_restart_i,
  // point channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mcpg_pkg::COORD_W-1:0] out_x_pos_o,
  output logic [mcpg_pkg::COORD_W-1:0] out_y_pos_o,
  output logic                         out_last_point_o
);
  import mcpg_pkg::*;

  // Level counter holds 0..MAX_DEGREE-1; it also indexes the stack memory.
  localparam int LVL_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  state_e               state_q, state_d;
  logic [DEG_W-1:0]     degree_q, degree_d;
  logic [LVL_W-1:0]     level_q, level_d;
  logic [POS_W-1:0]     axpos_q, axpos_d;
  logic [1:0]           heading_q, heading_d;
  logic [COORD_W-1:0]   x_q, x_d;
  logic [COORD_W-1:0]   y_q, y_d;
  logic [LEFT_W-1:0]    left_q, left_d;
  logic [FRAME_W-1:0]   top_q, top_d;

  logic                 out_valid_q, out_valid_d;
  logic [COORD_W-1:0]   out_x_q, out_y_q;
  logic                 out_last_q;
  logic                 out_load;

  // Expansion stack: frames of every open level below the top one.
  logic [FRAME_W-1:0]   stack_mem [MAX_DEGREE];
  logic                 mem_we;
  logic [LVL_W-1:0]     mem_waddr;
  logic [FRAME_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [LVL_W-1:0]     mem_raddr;
  logic [FRAME_W-1:0]   mem_rdata_q;

  logic [DEG_W-1:0]     deg_eff;
  logic                 in_accept;
  logic                 begin_walk;
  sym_e                 sym;
  logic                 sym_ok;
  logic [FRAME_W-1:0]   top_adv;

  always_comb begin
    deg_eff = (degree_q == '0) ? DEG_W'(1) : degree_q;
    if (deg_eff > DEG_W'(MAX_DEGREE)) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign top_adv    = top_q + FRAME_W'(1);

  always_comb begin
    state_d    = state_q;
    degree_d   = degree_q;
    level_d    = level_q;
    axpos_d    = axpos_q;
    heading_d  = heading_q;
    x_d        = x_q;
    y_d        = y_q;
    left_d     = left_q;
    top_d      = top_q;
    begin_walk = 1'b0;
    sym        = SYM_F;
    sym_ok     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = level_q - LVL_W'(1);
    mem_wdata  = top_adv;
    mem_re     = 1'b0;
    mem_raddr  = level_q - LVL_W'(2);

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_restart_i || (left_q == '0)) begin
            begin_walk = 1'b1;
            state_d    = ST_EMIT;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Fetch one symbol from the axiom or from the top frame.
        if (level_q == '0) begin
          if (axpos_q >= POS_W'(AXIOM_LEN)) begin
            begin_walk = 1'b1;
            state_d    = ST_EMIT;
          end else begin
            sym     = axiom_sym(axpos_q);
            sym_ok  = 1'b1;
            axpos_d = axpos_q + POS_W'(1);
          end
        end else if (top_q[POS_W-1:0] >= POS_W'(RULE_LEN)) begin
          // Drop the finished level; fetch the frame below if one is open.
          level_d = level_q - LVL_W'(1);
          if (level_q != LVL_W'(1)) begin
            mem_re  = 1'b1;
            state_d = ST_POP;
          end
        end else begin
          sym    = rule_sym(top_q[FRAME_W-1], top_q[POS_W-1:0]);
          sym_ok = 1'b1;
          top_d  = top_adv;
        end

        if (sym_ok) begin
          case (sym)
            SYM_L, SYM_R: begin
              if (({1'b0, level_q} + (LVL_W+1)'(1)) < (LVL_W+1)'(deg_eff)) begin
                // Push: park the advanced frame, open a new one on top.
                mem_we  = (level_q != '0);
                top_d   = {(sym == SYM_R), {POS_W{1'b0}}};
                level_d = level_q + LVL_W'(1);
              end
            end
            SYM_PLUS:  heading_d = heading_q + 2'd1;
            SYM_MINUS: heading_d = heading_q - 2'd1;
            SYM_F: begin
              case (heading_q)
                2'd0:    y_d = y_q + COORD_W'(1);
                2'd1:    x_d = x_q + COORD_W'(1);
                2'd2:    y_d = y_q - COORD_W'(1);
                default: x_d = x_q - COORD_W'(1);
              endcase
              left_d  = left_q - LEFT_W'(1);
              state_d = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        top_d   = mem_rdata_q;
        state_d = ST_WALK;
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (begin_walk) begin
      level_d   = '0;
      axpos_d   = '0;
      heading_d = '0;
      x_d       = COORD_W'((16'd1 << (deg_eff - DEG_W'(1))) - 16'd1);
      y_d       = '0;
      left_d    = LEFT_W'((31'd1 << {deg_eff, 1'b0}) - 31'd1);
    end

    // Degree writes must arrive only while idle; the block itself has no check. They force a fresh walk.
    if (cfg_we_i) begin
      degree_d = cfg_wdata_i;
      left_d   = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      degree_q    <= DEG_W'(1);
      level_q     <= '0;
      axpos_q     <= '0;
      heading_q   <= '0;
      x_q         <= '0;
      y_q         <= '0;
      left_q      <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      degree_q    <= degree_d;
      level_q     <= level_d;
      axpos_q     <= axpos_d;
      heading_q   <= heading_d;
      x_q         <= x_d;
      y_q         <= y_d;
      left_q      <= left_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload: hold while stalled, load a new point when free.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_last_q <= (left_q == '0);
    end
  end

  // Stack memory: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= stack_mem[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_pos_o      = out_x_q;
  assign out_y_pos_o      = out_y_q;
  assign out_last_point_o = out_last_q;

endmodule

>>> verif/moore_curve_point_generator_tb.sv
// ----------------------------------------------------------------------------
// moore_curve_point_generator_tb
// Self-checking testbench for the Moore curve point generator.
// ----------------------------------------------------------------------------
// A scoreboard object carries its own turtle: it expands the L-system one
// level frame at a time and predicts the point, and the last-point flag, that
// each accepted request beat must return. Every accepted point beat is checked
// field by field against the oldest prediction. Stimulus opens with a short
// directed walk (reset degree, zero and largest degree, restart and degree
// writes in mid-walk), then runs random walks over many degree settings. It
// does this under three idle profiles and with long output hold-offs and
// sender pauses.
// ----------------------------------------------------------------------------
module moore_curve_point_generator_tb;
  import mcpg_pkg::*;

  // Settle time after the points are drained, with margin.
  localparam int SETTLE_CYCLES    = 64;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int STUCK_LIMIT      = 2000;
  localparam int RESTART_ONE_IN   = 25;

  // --------------------------------------------------------------------------
  // Scoreboard: turtle predictor plus queue of expected points
  // --------------------------------------------------------------------------
  class curve_point_scoreboard;
    typedef enum logic [1:0] {HEAD_UP, HEAD_RIGHT, HEAD_DOWN, HEAD_LEFT} heading_e;
    typedef struct packed {
      logic [COORD_W-1:0] x_pos;
      logic [COORD_W-1:0] y_pos;
      logic               last_point;
    } point_t;

    sym_e axiom_seq [AXIOM_LEN] = '{SYM_L, SYM_F, SYM_L, SYM_PLUS, SYM_F,
                                    SYM_PLUS, SYM_L, SYM_F, SYM_L};
    sym_e rule_seq [2][RULE_LEN] = '{
      '{SYM_MINUS, SYM_R, SYM_F, SYM_PLUS, SYM_L, SYM_F, SYM_L, SYM_PLUS, SYM_F,
        SYM_R, SYM_MINUS},
      '{SYM_PLUS, SYM_L, SYM_F, SYM_MINUS, SYM_R, SYM_F, SYM_R, SYM_MINUS, SYM_F,
        SYM_L, SYM_PLUS}};

    logic [DEG_W-1:0]   degree;
    logic [FRAME_W-1:0] frames [DEFAULT_MAX_DEGREE];
    int unsigned        level;
    int unsigned        axiom_pos;
    heading_e           heading;
    logic [COORD_W-1:0] turtle_x;
    logic [COORD_W-1:0] turtle_y;
    logic [LEFT_W-1:0]  points_to_go;
    point_t             expected_points [$];

    int unsigned requests;
    int unsigned restarts;
    int unsigned points_checked;
    int unsigned curve_ends;
    int unsigned mismatches;

    function new();
      degree       = 1;
      level        = 0;
      axiom_pos    = 0;
      heading      = HEAD_UP;
      turtle_x     = '0;
      turtle_y     = '0;
      points_to_go = '0;
      foreach (frames[i]) frames[i] = '0;
    endfunction

    // A degree write also forces the next beat back to the start point.
    function void set_degree(input logic [DEG_W-1:0] d);
      degree       = d;
      points_to_go = '0;
    endfunction

    function int unsigned active_degree();
      return (degree == 0) ? 1 : int'(degree);
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void begin_walk();
      int unsigned d;
      d            = active_degree();
      level        = 0;
      axiom_pos    = 0;
      heading      = HEAD_UP;
      turtle_x     = COORD_W'((64'd1 << (d - 1)) - 1);
      turtle_y     = '0;
      points_to_go = LEFT_W'((64'd1 << (2 * d)) - 1);
      foreach (frames[i]) frames[i] = '0;
    endfunction

    // Fetch the next turn or step; expand L and R above the deepest level.
    // Returns 0 once the axiom is used up.
    function bit next_symbol(output sym_e sym);
      int unsigned        d;
      logic [FRAME_W-1:0] frame;
      d = active_degree();
      forever begin
        if (level == 0) begin
          if (axiom_pos >= AXIOM_LEN) return 1'b0;
          sym       = axiom_seq[axiom_pos];
          axiom_pos = (axiom_pos + 1) & 15;
        end else begin
          frame = frames[level - 1];
          if (frame[POS_W-1:0] >= RULE_LEN) begin
            level--;
            continue;
          end
          sym               = rule_seq[frame[POS_W]][frame[POS_W-1:0]];
          frames[level - 1] = frame + 1'b1;
        end
        if (sym == SYM_L || sym == SYM_R) begin
          if (level + 1 < d && level < DEFAULT_MAX_DEGREE) begin
            frames[level] = (sym == SYM_R) ? FRAME_W'(16) : '0;
            level++;
          end
          continue;
        end
        return 1'b1;
      end
    endfunction

    // Advance the turtle for one accepted request beat and queue its point.
    function void note_request(input logic restart);
      bit   fresh;
      sym_e sym;
      requests++;
      if (restart) restarts++;
      fresh = restart || (points_to_go == 0);
      if (!fresh) begin
        forever begin
          if (!next_symbol(sym)) begin
            fresh = 1'b1;
            break;
          end
          if (sym == SYM_PLUS) begin
            heading = heading_e'(heading + 2'd1);
          end else if (sym == SYM_MINUS) begin
            heading = heading_e'(heading - 2'd1);
          end else begin
            case (heading)
              HEAD_UP:    turtle_y = turtle_y + 1'b1;
              HEAD_RIGHT: turtle_x = turtle_x + 1'b1;
              HEAD_DOWN:  turtle_y = turtle_y - 1'b1;
              default:    turtle_x = turtle_x - 1'b1;
            endcase
            points_to_go = points_to_go - 1'b1;
            break;
          end
        end
      end
      if (fresh) begin_walk();
      expected_points.push_back('{turtle_x, turtle_y, points_to_go == 0});
    endfunction

    function void check_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
      point_t exp_pt;
      if (expected_points.size() == 0) begin
        $error("point beat (%0d, %0d, last %0b) with no request waiting", x, y, last);
        mismatches++;
        return;
      end
      exp_pt = expected_points.pop_front();
      points_checked++;
      if (last === 1'b1) curve_ends++;
      if (x !== exp_pt.x_pos) begin
        $error("x_pos: expected %0d, got %0d", exp_pt.x_pos, x);
        mismatches++;
      end
      if (y !== exp_pt.y_pos) begin
        $error("y_pos: expected %0d, got %0d", exp_pt.y_pos, y);
        mismatches++;
      end
      if (last !== exp_pt.last_point) begin
        $error("last_point: expected %0b, got %0b", exp_pt.last_point, last);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DEG_W-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_restart_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [COORD_W-1:0] out_x_pos_o;
  logic [COORD_W-1:0] out_y_pos_o;
  logic               out_last_point_o;

  moore_curve_point_generator DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_restart_i     (in_restart_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_x_pos_o      (out_x_pos_o),
    .out_y_pos_o      (out_y_pos_o),
    .out_last_point_o (out_last_point_o)
  );

  curve_point_scoreboard sb = new();

  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned degree_writes = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the edge where a beat is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_point(out_x_pos_o, out_y_pos_o, out_last_point_o);
      end
      if (in_valid_i && !in_stall_o) sb.note_request(in_restart_i);
    end
  end

  // --------------------------------------------------------------------------
  // Point receiver: random stall, plus long hold-offs on request so the
  // block fills up and has to stall the request channel.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either channel for too long
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Watchdog: no beat accepted for %0d cycles", STUCK_LIMIT);
    $display("moore_curve_point_generator_tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one request beat, with random gaps before it; return at the edge
  // that takes it. Scramble restart while valid is low.
  task automatic send_request(input logic restart);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i   <= 1'b0;
      in_restart_i <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_restart_i <= restart;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold the request channel until every predicted point has come back,
  // then let the block settle.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [DEG_W-1:0] d);
    drain_points();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= DEG_W'($urandom);
    sb.set_degree(d);
    degree_writes++;
  endtask

  // Random walk: mostly next-point beats, a restart now and then; pause the
  // sender halfway through when asked.
  task automatic random_walk(input int unsigned beats, input bit pause_halfway);
    for (int unsigned i = 0; i < beats; i++) begin
      if (pause_halfway && i == beats / 2) drain_points();
      send_request($urandom_range(RESTART_ONE_IN - 1) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [DEG_W-1:0] deg;
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_restart_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset degree is one: walk all four points, then wrap to the start.
    repeat (6) send_request(1'b0);
    // Restart in mid-walk.
    send_request(1'b1);
    send_request(1'b0);
    // Degree zero behaves as degree one.
    write_degree('0);
    repeat (5) send_request(1'b0);
    // Largest degree, with a restart deep into the walk.
    write_degree(4'd15);
    repeat (6) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    // Degree write in mid-walk drops the walk and starts over.
    write_degree(4'd2);
    repeat (3) send_request(1'b0);

    // Random walks under three idle profiles: sender light and receiver heavy,
    // then the reverse, then no idling at all.
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 75 : 0;
      rx_idle_pct = (mode == 0) ? 75 : (mode == 1) ? 13 : 0;
      for (int phase = 0; phase < 6; phase++) begin
        // Favor small degrees so walks complete and wrap.
        if ($urandom_range(9) < 7) deg = DEG_W'($urandom_range(1, 3));
        else                       deg = DEG_W'($urandom_range(15));
        write_degree(deg);
        if (phase == 2 && mode != 1) holds_asked++;
        random_walk($urandom_range(25, 50), phase == 4);
      end
    end

    drain_points();
    $display("Ran %0d request beats (%0d restarts) over %0d degree writes, zero and 15 included,",
             sb.requests, sb.restarts, degree_writes);
    $display("checking %0d points, %0d curve ends, under hold-offs and sender pauses.",
             sb.points_checked, sb.curve_ends);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("moore_curve_point_generator_tb: PASS");
    end else begin
      $display("moore_curve_point_generator_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> moore_curve_point_generator.f
rtl/mcpg_pkg.sv
rtl/moore_curve_point_generator.sv
verif/moore_curve_point_generator_tb.sv
